@@ rtl/mmtc_pkg.sv @@
package mmtc_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned ReadSlotW = 12;
  localparam int unsigned EpochW    = 8;

  localparam logic [CfgIdxW-1:0] REG_HASH_MULT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HASH_SHIFT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INDEX_BITS = 2'd2;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  typedef enum logic [2:0] {
    STAT_STORED    = 3'd0,
    STAT_MATCHED   = 3'd1,
    STAT_COLLISION = 3'd2,
    STAT_TOO_BIG   = 3'd3,
    STAT_FAILED    = 3'd4,
    STAT_READ      = 3'd5,
    STAT_STARTED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_LOOKUP,
    S_READ
  } state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_step_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [63:0]          key_word;
    logic [63:0]          value_word;
    logic [ReadSlotW-1:0] read_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] slot_index;
    logic        trial_failed;
    logic [63:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic new_trial;
  } tbl_ctrl_t;

  typedef struct packed {
    logic clearing;
    logic hit;
  } tbl_stat_t;

endpackage

@@ rtl/mmtc_mul64.sv @@
module mmtc_mul64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);
  import mmtc_pkg::*;

  mul_step_e   step_q, step_d;
  logic        done_q, done_d;
  logic [63:0] a_q, b_q;
  logic [63:0] ll_q;
  logic [31:0] x_q, x_d;
  logic [31:0] op_a, op_b;
  logic [63:0] p;

  // one shared 32x32 multiplier, low 64 bits of the product over three steps
  always_comb begin
    op_a = a_q[31:0];
    op_b = b_q[31:0];
    unique case (step_q)
      MUL_LH:  op_b = b_q[63:32];
      MUL_HL:  op_a = a_q[63:32];
      default: ;
    endcase
  end

  assign p = op_a * op_b;

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    x_d    = x_q;
    unique case (step_q)
      MUL_IDLE: if (go_i) step_d = MUL_LL;
      MUL_LL:   step_d = MUL_LH;
      MUL_LH: begin
        x_d    = p[31:0];
        step_d = MUL_HL;
      end
      MUL_HL: begin
        x_d    = x_q + p[31:0];
        done_d = 1'b1;
        step_d = MUL_IDLE;
      end
      default: step_d = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MUL_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == MUL_IDLE && go_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (step_q == MUL_LL) ll_q <= p;
    x_q <= x_d;
  end

  assign done_o = done_q;
  assign prod_o = {ll_q[63:32] + x_q, ll_q[31:0]};

endmodule

@@ rtl/mmtc_table.sv @@
module mmtc_table #(
  parameter int unsigned MAX_INDEX_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mmtc_pkg::tbl_ctrl_t           ctrl_i,
  input  logic [MAX_INDEX_BITS-1:0]     addr_i,
  input  logic [63:0]                   wr_value_i,
  output mmtc_pkg::tbl_stat_t           stat_o,
  output logic [63:0]                   rd_value_o
);
  import mmtc_pkg::*;

  localparam int unsigned Depth = 2 ** MAX_INDEX_BITS;

  typedef struct packed {
    logic [EpochW-1:0] tag;
    logic [63:0]       value;
  } entry_t;

  entry_t                    mem [Depth];
  entry_t                    rdata_q;
  entry_t                    wdata;
  logic                      we;
  logic [MAX_INDEX_BITS-1:0] waddr;

  logic [EpochW-1:0]         epoch_q, epoch_d;
  logic                      clr_q, clr_d;
  logic [MAX_INDEX_BITS-1:0] clr_addr_q, clr_addr_d;

  // an entry is valid when its tag equals the live epoch; tag zero is never live
  always_comb begin
    epoch_d    = epoch_q;
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {MAX_INDEX_BITS{1'b1}}) clr_d = 1'b0;
    end
    if (ctrl_i.new_trial) begin
      if (epoch_q == {EpochW{1'b1}}) begin
        epoch_d    = EpochW'(1);
        clr_d      = 1'b1;
        clr_addr_d = '0;
      end else begin
        epoch_d = epoch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q    <= EpochW'(1);
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      epoch_q    <= epoch_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we          = clr_q | ctrl_i.wr_en;
  assign waddr       = clr_q ? clr_addr_q : addr_i;
  assign wdata.tag   = clr_q ? '0 : epoch_q;
  assign wdata.value = clr_q ? '0 : wr_value_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (ctrl_i.rd_en) rdata_q <= mem[addr_i];
  end

  assign stat_o.clearing = clr_q;
  assign stat_o.hit      = (rdata_q.tag == epoch_q);
  assign rd_value_o      = rdata_q.value;

endmodule

@@ rtl/magic_multiplier_table_check.sv @@
// Multiply-shift hash checker. start is taken when busy is low; each add, read or
// start gives one result on result_o for a single cycle with done_o high, and
// the receiver cannot stall it. An add goes through three steps on the shared
// 32x32 multiplier, an add and shift, a table read, a compare-and-write and the
// result, in that order; an add that finds the trial already failed or the
// index too big skips the compare-and-write.
// The table lives in one synchronous memory tagged with an 8-bit trial epoch;
// busy stays high for a clearing pass over all 2^MAX_INDEX_BITS entries after
// reset and after every 255th start, when the epoch wraps. Command code 3 is
// dropped without a result. Configuration writes are taken at any time.
module magic_multiplier_table_check #(
  parameter int unsigned MAX_INDEX_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmtc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mmtc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              start,
  input  mmtc_pkg::in_item_t                item_i,
  output logic                              busy,
  output logic                              done_o,
  output mmtc_pkg::out_item_t               result_o
);
  import mmtc_pkg::*;

  localparam int unsigned EffW = $clog2(MAX_INDEX_BITS + 1);

  logic [63:0] mult_q;
  logic [5:0]  shift_q;
  logic [3:0]  idx_bits_q;

  state_e      state_q, state_d;
  logic        failed_q, failed_d;
  logic        done_q, done_d;
  out_item_t   res_q, res_d;
  in_item_t    item_q;
  logic [31:0] hash_q;
  logic        hash_en;

  logic                      accept;
  logic                      mul_go, mul_done;
  logic [63:0]               prod;
  tbl_ctrl_t                 tctrl;
  tbl_stat_t                 tstat;
  logic [MAX_INDEX_BITS-1:0] taddr;
  logic [63:0]               rd_value;
  logic [EffW-1:0]           eff_bits;
  logic                      too_big;

  logic [MAX_INDEX_BITS+ReadSlotW-1:0] slot_ext_in, slot_ext_q;
  logic [MAX_INDEX_BITS-1:0]           slot_in, slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q     <= 64'd1;
      shift_q    <= 6'd52;
      idx_bits_q <= 4'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HASH_MULT:  mult_q     <= cfg_data_i;
        REG_HASH_SHIFT: shift_q    <= cfg_data_i[5:0];
        REG_INDEX_BITS: idx_bits_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  mmtc_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (item_i.key_word),
    .b_i    (mult_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  mmtc_table #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tctrl),
    .addr_i     (taddr),
    .wr_value_i (item_q.value_word),
    .stat_o     (tstat),
    .rd_value_o (rd_value)
  );

  assign slot_ext_in = {{MAX_INDEX_BITS{1'b0}}, item_i.read_slot};
  assign slot_ext_q  = {{MAX_INDEX_BITS{1'b0}}, item_q.read_slot};
  assign slot_in     = slot_ext_in[MAX_INDEX_BITS-1:0];
  assign slot_q      = slot_ext_q[MAX_INDEX_BITS-1:0];

  assign eff_bits = (32'(idx_bits_q) > MAX_INDEX_BITS) ? EffW'(MAX_INDEX_BITS)
                                                       : EffW'(idx_bits_q);
  assign too_big  = (hash_q >> eff_bits) != 32'd0;

  assign busy   = (state_q != S_IDLE) | tstat.clearing;
  assign accept = start & ~busy;

  always_comb begin
    state_d  = state_q;
    failed_d = failed_q;
    done_d   = 1'b0;
    res_d    = res_q;
    mul_go   = 1'b0;
    hash_en  = 1'b0;
    tctrl    = '0;
    taddr    = hash_q[MAX_INDEX_BITS-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            CMD_ADD: begin
              mul_go  = 1'b1;
              state_d = S_MUL;
            end
            CMD_READ: begin
              tctrl.rd_en = 1'b1;
              taddr       = slot_in;
              state_d     = S_READ;
            end
            CMD_START: begin
              tctrl.new_trial    = 1'b1;
              failed_d           = 1'b0;
              done_d             = 1'b1;
              res_d.status       = STAT_STARTED;
              res_d.slot_index   = '0;
              res_d.trial_failed = 1'b0;
              res_d.read_value   = '0;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          hash_en = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_d.slot_index = hash_q;
        res_d.read_value = '0;
        if (failed_q) begin
          done_d             = 1'b1;
          res_d.status       = STAT_FAILED;
          res_d.trial_failed = 1'b1;
          state_d            = S_IDLE;
        end else if (too_big) begin
          failed_d           = 1'b1;
          done_d             = 1'b1;
          res_d.status       = STAT_TOO_BIG;
          res_d.trial_failed = 1'b1;
          state_d            = S_IDLE;
        end else begin
          tctrl.rd_en = 1'b1;
          state_d     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // sole access in flight, so the write-back needs no forwarding
        done_d = 1'b1;
        if (!tstat.hit) begin
          tctrl.wr_en        = 1'b1;
          res_d.status       = STAT_STORED;
          res_d.trial_failed = 1'b0;
        end else if (rd_value == item_q.value_word) begin
          res_d.status       = STAT_MATCHED;
          res_d.trial_failed = 1'b0;
        end else begin
          failed_d           = 1'b1;
          res_d.status       = STAT_COLLISION;
          res_d.trial_failed = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_READ: begin
        done_d             = 1'b1;
        res_d.status       = STAT_READ;
        res_d.slot_index   = 32'(slot_q);
        res_d.trial_failed = failed_q;
        res_d.read_value   = tstat.hit ? rd_value : 64'd0;
        state_d            = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      failed_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      failed_q <= failed_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) item_q <= item_i;
    if (hash_en) hash_q <= 32'(prod >> shift_q);
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/mmtc_check.sv @@
module mmtc_check #(
  parameter int unsigned MAX_INDEX_BITS = 12
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input mmtc_pkg::in_item_t            item_i,
  input logic                          busy,
  input logic                          done_o,
  input mmtc_pkg::out_item_t           result_o
);
  import mmtc_pkg::*;

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == CMD_START)
      |=> (done_o && result_o.status == STAT_STARTED && !result_o.trial_failed))
    else $error("start item without a started result");

  a_fail_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_COLLISION || result_o.status == STAT_TOO_BIG
                || result_o.status == STAT_FAILED)) |-> result_o.trial_failed)
    else $error("failing status without sticky flag");

  a_pass_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_STORED || result_o.status == STAT_MATCHED))
      |-> !result_o.trial_failed)
    else $error("table update reported on a failed trial");

  a_read_only_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != STAT_READ) |-> (result_o.read_value == 64'd0))
    else $error("value on a non-read result");

  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == STAT_READ)
      |-> ((result_o.slot_index >> MAX_INDEX_BITS) == 32'd0))
    else $error("read index beyond table");

endmodule

bind magic_multiplier_table_check mmtc_check #(
  .MAX_INDEX_BITS(MAX_INDEX_BITS)
) u_mmtc_check (.*);

@@ test/magic_multiplier_table_check_test.sv @@
module magic_multiplier_table_check_test;
  import mmtc_pkg::*;

  localparam int          TBL_BITS     = 12;
  localparam int          TBL_DEPTH    = 1 << TBL_BITS;
  localparam int          TARGET_ITEMS = 1550;
  localparam int          QUIET_ITEMS  = 200;
  localparam int          SETTLE_CYC   = 12;
  localparam int          LIMIT_CYC    = 600000;
  localparam int          WRAP_STARTS  = 260;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [63:0] ALL_ONES     = '1;
  localparam logic [63:0] VAL_A        = 64'h0123_4567_89AB_CDEF;
  localparam out_item_t   NO_WANT      = '0;

  typedef struct packed {
    logic        is_reg;
    logic [1:0]  code;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [11:0] slot;
    logic        typed;
    out_item_t   want;
  } dir_row_t;

  localparam int N_ROWS = 35;

  // reset settings: multiplier 1, shift 52, index_bits 12, so the index is key[63:52]
  dir_row_t dir_table [N_ROWS] = '{
    '{1'b0, CMD_START, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_STARTED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd0, VAL_A, 12'd0, 1'b1, '{STAT_STORED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, ALL_ONES, ALL_ONES, 12'hfff, 1'b1,
      '{STAT_STORED, 32'd4095, 1'b0, 64'd0}},
    '{1'b0, CMD_READ, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_READ, 32'd0, 1'b0, VAL_A}},
    '{1'b0, CMD_READ, ALL_ONES, ALL_ONES, 12'hfff, 1'b1,
      '{STAT_READ, 32'd4095, 1'b0, ALL_ONES}},
    '{1'b0, CMD_ADD, 64'h000F_FFFF_FFFF_FFFF, VAL_A, 12'd0, 1'b1,
      '{STAT_MATCHED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'h8000_0000_0000_0000, 64'd0, 12'd0, 1'b1,
      '{STAT_STORED, 32'd2048, 1'b0, 64'd0}},
    '{1'b0, CMD_READ, 64'd0, 64'd0, 12'd2048, 1'b1, '{STAT_READ, 32'd2048, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd1, ~VAL_A, 12'd0, 1'b1, '{STAT_COLLISION, 32'd0, 1'b1, 64'd0}},
    '{1'b0, CMD_ADD, ALL_ONES, ALL_ONES, 12'd0, 1'b1, '{STAT_FAILED, 32'd4095, 1'b1, 64'd0}},
    '{1'b0, CMD_READ, 64'd0, 64'd0, 12'hfff, 1'b1, '{STAT_READ, 32'd4095, 1'b1, ALL_ONES}},
    '{1'b0, CMD_UNUSED, ALL_ONES, ALL_ONES, 12'hfff, 1'b0, NO_WANT},
    '{1'b0, CMD_START, ALL_ONES, ALL_ONES, 12'hfff, 1'b1, '{STAT_STARTED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_READ, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_READ, 32'd0, 1'b0, 64'd0}},
    '{1'b1, REG_HASH_SHIFT, 64'd0, 64'd0, 12'd0, 1'b0, NO_WANT},
    '{1'b1, REG_INDEX_BITS, 64'd4, 64'd0, 12'd0, 1'b0, NO_WANT},
    // product above 32 bits: index is truncated, not too big
    '{1'b0, CMD_ADD, 64'h0000_0001_0000_000F, ALL_ONES, 12'd0, 1'b1,
      '{STAT_STORED, 32'd15, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd16, 64'd0, 12'd0, 1'b1, '{STAT_TOO_BIG, 32'd16, 1'b1, 64'd0}},
    '{1'b0, CMD_ADD, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_FAILED, 32'd0, 1'b1, 64'd0}},
    '{1'b1, REG_INDEX_BITS, 64'd0, 64'd0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, CMD_START, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_STARTED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd0, 64'd1, 12'd0, 1'b1, '{STAT_STORED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd1, 64'd1, 12'd0, 1'b1, '{STAT_TOO_BIG, 32'd1, 1'b1, 64'd0}},
    // index_bits above the table size acts as the full table
    '{1'b1, REG_INDEX_BITS, 64'd15, 64'd0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, CMD_START, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_STARTED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'hFFFF_FFFF_0000_0FFF, 64'd7, 12'd0, 1'b1,
      '{STAT_STORED, 32'd4095, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd4096, 64'd7, 12'd0, 1'b1, '{STAT_TOO_BIG, 32'd4096, 1'b1, 64'd0}},
    '{1'b1, REG_HASH_MULT, ALL_ONES, 64'd0, 12'd0, 1'b0, NO_WANT},
    '{1'b1, REG_HASH_SHIFT, 64'd63, 64'd0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, CMD_START, 64'd0, 64'd0, 12'd0, 1'b1, '{STAT_STARTED, 32'd0, 1'b0, 64'd0}},
    '{1'b0, CMD_ADD, 64'd1, VAL_A, 12'd0, 1'b0, NO_WANT},
    '{1'b0, CMD_ADD, 64'd3, VAL_A, 12'd0, 1'b0, NO_WANT},
    '{1'b1, REG_HASH_MULT, 64'd0, 64'd0, 12'd0, 1'b0, NO_WANT},
    '{1'b0, CMD_ADD, 64'hDEAD_BEEF_CAFE_F00D, ~VAL_A, 12'd0, 1'b0, NO_WANT},
    '{1'b0, CMD_READ, 64'd0, 64'd0, 12'd1, 1'b0, NO_WANT}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                start;
  in_item_t            item_i;
  logic                busy;
  logic                done_o;
  out_item_t           result_o;

  magic_multiplier_table_check u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .item_i     (item_i),
    .busy       (busy),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [63:0]          reg_mult;
  logic [5:0]           reg_shift;
  logic [3:0]           reg_ibits;
  logic [63:0]          tbl_value [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] tbl_live;
  logic [TBL_DEPTH-1:0] tbl_ever;
  logic                 trial_dead;
  int                   written_slots [$];

  out_item_t pending_results [$];
  out_item_t mon_want;
  int        err_count  = 0;
  int        items_done = 0;
  int        cycle_count = 0;
  bit        idle_on;

  logic [63:0] pool_key [$];
  logic [63:0] pool_val [$];

  function automatic bit hash_table_predict(input in_item_t it, output out_item_t res);
    logic [63:0] prod;
    logic [31:0] idx;
    logic [3:0]  eff;
    bit          produced;
    res      = '0;
    produced = 1'b1;
    if (it.cmd == CMD_START) begin
      tbl_live   = '0;
      trial_dead = 1'b0;
      res.status = STAT_STARTED;
    end else if (it.cmd == CMD_READ) begin
      res.status     = STAT_READ;
      res.slot_index = 32'(it.read_slot);
      res.read_value = tbl_live[it.read_slot] ? tbl_value[it.read_slot] : 64'd0;
    end else if (it.cmd == CMD_ADD) begin
      prod = it.key_word * reg_mult;
      idx  = 32'(prod >> reg_shift);
      eff  = (reg_ibits > 4'(TBL_BITS)) ? 4'(TBL_BITS) : reg_ibits;
      res.slot_index = idx;
      if (trial_dead) begin
        res.status = STAT_FAILED;
      end else if (64'(idx) >= (64'd1 << eff)) begin
        trial_dead = 1'b1;
        res.status = STAT_TOO_BIG;
      end else if (!tbl_live[idx[TBL_BITS-1:0]]) begin
        tbl_live[idx[TBL_BITS-1:0]]  = 1'b1;
        tbl_value[idx[TBL_BITS-1:0]] = it.value_word;
        if (!tbl_ever[idx[TBL_BITS-1:0]]) begin
          tbl_ever[idx[TBL_BITS-1:0]] = 1'b1;
          written_slots = {written_slots, int'(idx)};
        end
        res.status = STAT_STORED;
      end else if (tbl_value[idx[TBL_BITS-1:0]] == it.value_word) begin
        res.status = STAT_MATCHED;
      end else begin
        trial_dead = 1'b1;
        res.status = STAT_COLLISION;
      end
    end else begin
      produced = 1'b0;
    end
    res.trial_failed = trial_dead;
    return produced;
  endfunction

  task automatic issue(input in_item_t it, input bit typed, input out_item_t typed_want);
    out_item_t pred;
    int        gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 25) gap = $urandom_range(8, 1);
    if (hash_table_predict(it, pred)) begin
      pending_results = {pending_results, (typed ? typed_want : pred)};
      items_done++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_HASH_MULT) reg_mult = data;
    else if (idx == REG_HASH_SHIFT) reg_shift = data[5:0];
    else if (idx == REG_INDEX_BITS) reg_ibits = data[3:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t noise_item(input logic [1:0] cmd);
    in_item_t it;
    it.cmd        = cmd;
    it.key_word   = rand64();
    it.value_word = rand64();
    it.read_slot  = 12'($urandom);
    return it;
  endfunction

  task automatic pick_settings();
    logic [3:0]  ib;
    logic [3:0]  eff;
    logic [63:0] mult;
    logic [5:0]  base;
    logic [5:0]  shift;
    int          r;
    ib   = ($urandom_range(9) < 6) ? 4'($urandom_range(12, 3)) : 4'($urandom_range(15));
    eff  = (ib > 4'(TBL_BITS)) ? 4'(TBL_BITS) : ib;
    r    = $urandom_range(9);
    mult = (r == 0) ? 64'd0 : (r == 1) ? ALL_ONES : (rand64() | 64'd1);
    base = (eff == 0) ? 6'd63 : 6'(64 - eff);
    r    = $urandom_range(9);
    shift = (r < 6) ? base : (r < 8) ? base - 6'd1 : 6'($urandom_range(63));
    settle();
    write_reg(REG_HASH_MULT, mult);
    write_reg(REG_HASH_SHIFT, 64'(shift));
    write_reg(REG_INDEX_BITS, 64'(ib));
  endtask

  task automatic run_trial();
    in_item_t it;
    int       steps;
    int       r;
    int       k;
    idle_on = (items_done < TARGET_ITEMS - QUIET_ITEMS) && ($urandom_range(3) != 0);
    pool_key.delete();
    pool_val.delete();
    issue(noise_item(CMD_START), 1'b0, NO_WANT);
    steps = $urandom_range(40, 4);
    for (int s = 0; s < steps; s++) begin
      r  = $urandom_range(99);
      it = noise_item(CMD_ADD);
      if (r < 45) begin
        if (pool_key.size() == 0 || r < 22) begin
          if (pool_val.size() != 0 && $urandom_range(4) == 0)
            it.value_word = pool_val[$urandom_range(pool_val.size() - 1)];
          pool_key = {pool_key, it.key_word};
          pool_val = {pool_val, it.value_word};
        end else begin
          k = $urandom_range(pool_key.size() - 1);
          it.key_word = pool_key[k];
          if ($urandom_range(9) != 0) it.value_word = pool_val[k];
        end
      end else if (r < 60) begin
        if (written_slots.size() != 0) begin
          it.cmd       = CMD_READ;
          it.read_slot = 12'(written_slots[$urandom_range(written_slots.size() - 1)]);
        end
      end else if (r < 65) begin
        it.cmd = CMD_UNUSED;
      end else if (r < 68) begin
        it.cmd = CMD_START;
        pool_key.delete();
        pool_val.delete();
      end else if (r < 71) begin
        if (idle_on) begin
          hold_until_drained();
          continue;
        end
      end
      issue(it, 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYC) begin
      $display("magic_multiplier_table_check_test: errors");
      $finish;
    end
  end

  task automatic flag_field(input string what, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    if (want_v !== got_v) begin
      err_count++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result expected none, got %0h", $time, result_o);
      end else begin
        mon_want = pending_results.pop_front();
        flag_field("status", 64'(mon_want.status), 64'(result_o.status));
        flag_field("slot_index", 64'(mon_want.slot_index), 64'(result_o.slot_index));
        flag_field("trial_failed", 64'(mon_want.trial_failed), 64'(result_o.trial_failed));
        flag_field("read_value", mon_want.read_value, result_o.read_value);
      end
    end
  end

  initial begin
    in_item_t it;
    bit       wrapped;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    start      = 1'b0;
    item_i     = '0;
    reg_mult   = 64'd1;
    reg_shift  = 6'd52;
    reg_ibits  = 4'd12;
    tbl_live   = '0;
    tbl_ever   = '0;
    trial_dead = 1'b0;
    idle_on    = 1'b1;
    wrapped    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_reg) begin
        settle();
        write_reg(dir_table[i].code, dir_table[i].word_a);
      end else begin
        it.cmd        = dir_table[i].code;
        it.key_word   = dir_table[i].word_a;
        it.value_word = dir_table[i].word_b;
        it.read_slot  = dir_table[i].slot;
        issue(it, dir_table[i].typed, dir_table[i].want);
      end
    end

    while (items_done < TARGET_ITEMS) begin
      pick_settings();
      repeat ($urandom_range(4, 2)) run_trial();
      // enough starts to wrap the trial epoch and force a clearing pass
      if (!wrapped && items_done > TARGET_ITEMS / 2) begin
        wrapped = 1'b1;
        repeat (WRAP_STARTS) issue(noise_item(CMD_START), 1'b0, NO_WANT);
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("magic_multiplier_table_check_test: clean");
    end else begin
      $display("magic_multiplier_table_check_test: errors");
    end
    $finish;
  end

endmodule

@@ magic_multiplier_table_check.f @@
rtl/mmtc_pkg.sv
rtl/mmtc_mul64.sv
rtl/mmtc_table.sv
rtl/magic_multiplier_table_check.sv
rtl/mmtc_check.sv
test/magic_multiplier_table_check_test.sv
